>>> rtl/core/gdet_pkg.sv
// Shared types and constants for the circular gesture detector.
// Holds the word formats, direction and gesture codes and register indexes.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package gdet_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_WINDOW = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PER  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS       = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [6:0]  THRESHOLD_RESET   = 7'd10;
  localparam logic [15:0] TURN_WINDOW_RESET = 16'd350;
  localparam logic [15:0] SAMPLE_PER_RESET  = 16'd10;
  localparam logic [2:0]  STEPS_RESET       = 3'd4;

  typedef enum logic [2:0] {
    DIR_NULL  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_UP    = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    GEST_NONE = 2'd0,
    GEST_CW   = 2'd1,
    GEST_CCW  = 2'd2
  } gesture_t;

  typedef struct packed {
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [15:0]       now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0] gesture;
    logic [2:0] sampled_direction;
  } out_word_t;

  // What the sampler hands to the rotation tracker for one word.
  typedef struct packed {
    logic evaluated;
    dir_t dir;
  } sample_t;

endpackage

>>> rtl/core/gdet_sampler.sv
// Motion accumulator and direction classifier of the gesture detector.
// Keeps the saturating X/Y sums and the time of the last evaluation.
// Depends on gdet_pkg.
`timescale 1ns / 1ps

module gdet_sampler import gdet_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  in_word_t word,
  input  logic [6:0]  threshold,
  input  logic [15:0] sample_period,
  output sample_t  sample
);

  logic signed [7:0] sum_x, sum_y;
  logic signed [7:0] sum_x_next, sum_y_next;
  logic [15:0] last_sample_time;
  logic [15:0] since_sample;
  logic [7:0]  mag_x, mag_y;
  logic signed [7:0] thr_pos, thr_neg;
  dir_t dir;

  function automatic logic signed [7:0] sat_add8(input logic signed [7:0] a,
                                                  input logic signed [7:0] b);
    logic signed [8:0] s;
    s = {a[7], a} + {b[7], b};
    if (s[8] != s[7]) begin
      return s[8] ? 8'sh80 : 8'sh7F;
    end
    return s[7:0];
  endfunction

  assign sum_x_next = sat_add8(sum_x, word.delta_x);
  assign sum_y_next = sat_add8(sum_y, word.delta_y);

  assign since_sample = word.now_ms - last_sample_time;

  // Magnitudes are unsigned so that -128 reads as 128.
  assign mag_x = sum_x_next[7] ? 8'(-sum_x_next) : 8'(sum_x_next);
  assign mag_y = sum_y_next[7] ? 8'(-sum_y_next) : 8'(sum_y_next);
  assign thr_pos = $signed({1'b0, threshold});
  assign thr_neg = -thr_pos;

  always_comb begin
    dir = DIR_NULL;
    if (mag_x > mag_y) begin
      if (sum_x_next > thr_pos) begin
        dir = DIR_RIGHT;
      end else if (sum_x_next < thr_neg) begin
        dir = DIR_LEFT;
      end
    end else begin
      if (sum_y_next > thr_pos) begin
        dir = DIR_DOWN;
      end else if (sum_y_next < thr_neg) begin
        dir = DIR_UP;
      end
    end
  end

  always_comb begin
    sample.evaluated = (since_sample >= sample_period);
    sample.dir       = sample.evaluated ? dir : DIR_NULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      last_sample_time <= '0;
    end else if (step) begin
      if (sample.evaluated) begin
        sum_x <= '0;
        sum_y <= '0;
        last_sample_time <= word.now_ms;
      end else begin
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
      end
    end
  end

endmodule

>>> rtl/core/gdet_rotation.sv
// Rotation tracker of the gesture detector.
// Counts clockwise and counterclockwise direction steps inside a turn window.
// Depends on gdet_pkg.
`timescale 1ns / 1ps

module gdet_rotation import gdet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  sample_t     sample,
  input  logic [15:0] now_ms,
  input  logic [15:0] turn_window,
  input  logic [2:0]  steps_per_turn,
  output gesture_t    gesture
);

  dir_t        previous_direction;
  logic signed [3:0] rotation_count;
  logic [15:0] turn_start_time;
  logic        turn_active;

  logic        change, expired, cw, ccw;
  logic [15:0] since_start;
  logic signed [4:0] count_base, count_step, spt_pos, spt_neg;

  assign change = sample.evaluated && (sample.dir != DIR_NULL) &&
                  (sample.dir != previous_direction);
  assign since_start = now_ms - turn_start_time;
  assign expired = turn_active && (since_start > turn_window);

  always_comb begin
    cw  = ((previous_direction == DIR_RIGHT) && (sample.dir == DIR_DOWN)) ||
          ((previous_direction == DIR_DOWN)  && (sample.dir == DIR_LEFT)) ||
          ((previous_direction == DIR_LEFT)  && (sample.dir == DIR_UP))   ||
          ((previous_direction == DIR_UP)    && (sample.dir == DIR_RIGHT));
    ccw = ((previous_direction == DIR_RIGHT) && (sample.dir == DIR_UP))   ||
          ((previous_direction == DIR_UP)    && (sample.dir == DIR_LEFT)) ||
          ((previous_direction == DIR_LEFT)  && (sample.dir == DIR_DOWN)) ||
          ((previous_direction == DIR_DOWN)  && (sample.dir == DIR_RIGHT));
  end

  assign count_base = expired ? 5'sd0 : 5'(rotation_count);
  assign spt_pos    = $signed({2'b00, steps_per_turn});
  assign spt_neg    = -spt_pos;

  always_comb begin
    count_step = count_base;
    if (cw) begin
      count_step = count_base + 5'sd1;
    end else if (ccw) begin
      count_step = count_base - 5'sd1;
    end
  end

  // The clockwise test wins a tie, which arises when steps_per_turn and the step count are both zero.
  always_comb begin
    gesture = GEST_NONE;
    if (change) begin
      priority if (count_step >= spt_pos) begin
        gesture = GEST_CW;
      end else if (count_step <= spt_neg) begin
        gesture = GEST_CCW;
      end else begin
        gesture = GEST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_direction <= DIR_NULL;
      rotation_count     <= '0;
      turn_start_time    <= '0;
      turn_active        <= 1'b0;
    end else if (step && change) begin
      previous_direction <= sample.dir;
      if (!turn_active || expired) begin
        turn_start_time <= now_ms;
      end
      if (gesture != GEST_NONE) begin
        rotation_count <= '0;
        turn_active    <= 1'b0;
      end else begin
        rotation_count <= count_step[3:0];
        turn_active    <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/circular_gesture_detector_top.sv
// Circular gesture detector: an accepted word goes from the input register through
// the evaluation to the output register; throughput one word per cycle while the
// output is not stalled, set by the single evaluation stage between them.
// Reset (rst, synchronous, active high) clears the sums and the rotation state,
// empties both pipeline registers and loads the register defaults.
// Depends on gdet_pkg, gdet_sampler and gdet_rotation.
`timescale 1ns / 1ps

module circular_gesture_detector_top import gdet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Motion word input.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  // Result word output.
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
  logic [6:0]  threshold;
  logic [15:0] turn_window;
  logic [15:0] sample_period;
  logic [2:0]  steps_per_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESHOLD_RESET;
      turn_window    <= TURN_WINDOW_RESET;
      sample_period  <= SAMPLE_PER_RESET;
      steps_per_turn <= STEPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold      <= cfg_data[6:0];
        REG_TURN_WINDOW: turn_window    <= cfg_data[15:0];
        REG_SAMPLE_PER:  sample_period  <= cfg_data[15:0];
        REG_STEPS:       steps_per_turn <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // The input register holds one accepted word. The word is evaluated in the
  // cycle it moves on to the output register, and that same edge updates the
  // detector state, so the next word always sees the state its predecessor left.
  logic     in_full;
  in_word_t in_q;
  logic     out_full;
  out_word_t out_q;
  logic     advance;

  sample_t  sample;
  gesture_t gesture;

  assign advance  = in_full && (!out_full || out_ready);
  // A new word is taken whenever the input register is empty or moves on
  // in the same cycle, so a waiting result stalls the input side only once the input register is full.
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  gdet_sampler u_sampler (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .word          (in_q),
    .threshold     (threshold),
    .sample_period (sample_period),
    .sample        (sample)
  );

  gdet_rotation u_rotation (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .sample         (sample),
    .now_ms         (in_q.now_ms),
    .turn_window    (turn_window),
    .steps_per_turn (steps_per_turn),
    .gesture        (gesture)
  );

  // The output register keeps its word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q.gesture           <= gesture;
      out_q.sampled_direction <= sample.dir;
    end
  end

  assign out_valid = out_full;
  assign out_data  = out_q;

endmodule

>>> rtl/core/gdet_checker.sv
// Port-level checks for the circular gesture detector.
// Watches only the top-level ports; bound to circular_gesture_detector_top below.
// Depends on gdet_pkg.
`timescale 1ns / 1ps

module gdet_checker import gdet_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A result waiting for the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed or vanished while stalled");

  // A turn can only be reported together with the direction that completed it.
  a_gesture_has_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.gesture != GEST_NONE) |-> (out_data.sampled_direction != DIR_NULL))
    else $error("gesture reported without a sampled direction");

  // An accepted word reaches the output register when nothing stalls.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted word did not reach the output");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind circular_gesture_detector_top gdet_checker u_gdet_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
